@@ hw/rtl/lesf_pkg.sv @@
// ----------------------------------------------------------------------------
// lesf_pkg
// shared constants and types of the largest empty square finder
// ----------------------------------------------------------------------------
package lesf_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 11;
  localparam int SCORE_W = 11;
  localparam int CHAR_W  = 8;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [CNT_W-1:0]   WIDTH_MAX = CNT_W'(MAX_COLS);
  localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(MAX_ROWS - 1);

  localparam logic REG_EMPTY_CHAR = 1'b0;
  localparam logic REG_ROW_WIDTH  = 1'b1;

  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;
  localparam logic [CNT_W-1:0]  ROW_WIDTH_RST  = 11'd1024;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             free;
    logic             last;
  } cell_t;

  typedef struct packed {
    logic busy;
    logic last;
  } stage_t;

endpackage

@@ hw/rtl/largest_empty_square_finder.sv @@
// ----------------------------------------------------------------------------
// largest_empty_square_finder
// maximal square scan over a raster grid of characters, one cell per cycle
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_*      in   tdata[7:0] cell_char, tlast last_cell
// m_*      out  tuser found, tdata best_row/best_col/best_size
// cfg_*    in   index 0 empty_char, index 1 row_width
//
// one cell per cycle; the position tracker is combinational and the row
// buffer read is issued at the edge that takes the cell, which then moves
// into the score stage that writes its score back
// the result becomes valid at the edge where the score stage fires on the last cell
// reset clears position, scores and best; the row buffer is not cleared
// input stalls only while a finished result waits and the next last cell
// has reached the score stage
// ----------------------------------------------------------------------------
module largest_empty_square_finder
  import lesf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] cell_char
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [9:0] best_row, [19:10] best_col, [30:20] best_size
  output logic              m_tuser,   // [0] found
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CNT_W-1:0]  cfg_data
);

  logic [CHAR_W-1:0]  empty_char;
  logic [CNT_W-1:0]   row_width;
  logic               accept;
  cell_t              item;
  logic [SCORE_W-1:0] up_rd;
  logic               wr_en;
  logic [COL_W-1:0]   wr_col;
  logic [SCORE_W-1:0] wr_score;
  stage_t             stage;
  logic [ROW_W-1:0]   best_row;
  logic [COL_W-1:0]   best_col;
  logic [SCORE_W-1:0] best_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_char <= EMPTY_CHAR_RST;
      row_width  <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EMPTY_CHAR: empty_char <= cfg_data[CHAR_W-1:0];
        REG_ROW_WIDTH:  row_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  lesf_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cell_char  (s_tdata),
    .last_cell  (s_tlast),
    .empty_char (empty_char),
    .row_width  (row_width),
    .item       (item)
  );

  lesf_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_COLS)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_col),
    .wdata (wr_score),
    .re    (accept),
    .raddr (item.col),
    .rdata (up_rd)
  );

  lesf_score u_score (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .up_rd     (up_rd),
    .wr_en     (wr_en),
    .wr_col    (wr_col),
    .wr_score  (wr_score),
    .ready     (s_tready),
    .stage     (stage),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_found (m_tuser),
    .res_row   (best_row),
    .res_col   (best_col),
    .res_size  (best_size)
  );

  assign m_tdata = {1'b0, best_size, best_col, best_row};

  a_no_find_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("empty result carries nonzero position or size");

  a_find_size: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (best_size != '0))
    else $error("found result with zero size");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (stage.busy && stage.last && m_tvalid && !m_tready))
    else $error("input stalled without a waiting result");

  a_size_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (best_size <= WIDTH_MAX))
    else $error("square larger than a row");

endmodule

@@ hw/rtl/lesf_ram.sv @@
// ----------------------------------------------------------------------------
// lesf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lesf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/lesf_scan.sv @@
// ----------------------------------------------------------------------------
// lesf_scan
// raster position tracking; gives the row and column of each incoming cell
// ----------------------------------------------------------------------------
module lesf_scan
  import lesf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CHAR_W-1:0] cell_char,
  input  logic              last_cell,
  input  logic [CHAR_W-1:0] empty_char,
  input  logic [CNT_W-1:0]  row_width,
  output cell_t             item
);

  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] col_index;
  logic [ROW_W-1:0] row_index_next;
  logic [COL_W-1:0] col_index_next;
  logic [CNT_W-1:0] width;
  logic             wrap;
  logic [CNT_W-1:0] col_inc;

  function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
    return (r == ROW_LAST) ? r : r + ROW_W'(1);
  endfunction

  always_comb begin
    if (row_width == '0) begin
      width = CNT_W'(1);
    end else if (row_width > WIDTH_MAX) begin
      width = WIDTH_MAX;
    end else begin
      width = row_width;
    end
    wrap      = ({1'b0, col_index} >= width);
    item.col  = wrap ? '0 : col_index;
    item.row  = wrap ? row_step(row_index) : row_index;
    item.free = (cell_char == empty_char);
    item.last = last_cell;
    col_inc   = {1'b0, item.col} + CNT_W'(1);
    if (last_cell) begin
      row_index_next = '0;
      col_index_next = '0;
    end else if (col_inc >= width) begin
      row_index_next = row_step(item.row);
      col_index_next = '0;
    end else begin
      row_index_next = item.row;
      col_index_next = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      row_index <= row_index_next;
      col_index <= col_index_next;
    end
  end

endmodule

@@ hw/rtl/lesf_score.sv @@
// ----------------------------------------------------------------------------
// lesf_score
// score stage: combines the row buffer read with left and diagonal scores,
// writes the score back, tracks the best square and holds the result
// ----------------------------------------------------------------------------
module lesf_score
  import lesf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  cell_t              item,
  input  logic [SCORE_W-1:0] up_rd,
  output logic               wr_en,
  output logic [COL_W-1:0]   wr_col,
  output logic [SCORE_W-1:0] wr_score,
  output logic               ready,
  output stage_t             stage,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_found,
  output logic [ROW_W-1:0]   res_row,
  output logic [COL_W-1:0]   res_col,
  output logic [SCORE_W-1:0] res_size
);

  logic               busy;
  cell_t              cur;
  logic               fwd;
  logic [SCORE_W-1:0] fwd_score;
  logic [SCORE_W-1:0] left_score;
  logic [SCORE_W-1:0] diag_score;
  logic [SCORE_W-1:0] top_size;
  logic [ROW_W-1:0]   top_row;
  logic [COL_W-1:0]   top_col;
  logic [SCORE_W-1:0] top_size_next;
  logic [ROW_W-1:0]   top_row_next;
  logic [COL_W-1:0]   top_col_next;
  logic [SCORE_W-1:0] up;
  logic [SCORE_W-1:0] least;
  logic [SCORE_W-1:0] score;
  logic               fire;

  always_comb begin
    up    = fwd ? fwd_score : up_rd;
    least = (left_score < up) ? left_score : up;
    least = (least < diag_score) ? least : diag_score;
    if (!cur.free) begin
      score = '0;
    end else if (cur.row == '0 || cur.col == '0) begin
      score = SCORE_W'(1);
    end else if (least == SCORE_MAX) begin
      score = SCORE_MAX;
    end else begin
      score = least + SCORE_W'(1);
    end
    if (score > top_size) begin
      top_size_next = score;
      top_row_next  = cur.row;
      top_col_next  = cur.col;
    end else begin
      top_size_next = top_size;
      top_row_next  = top_row;
      top_col_next  = top_col;
    end
  end

  assign fire       = busy && (!cur.last || !res_valid || res_ready);
  assign ready      = !busy || fire;
  assign wr_en      = fire;
  assign wr_col     = cur.col;
  assign wr_score   = score;
  assign stage.busy = busy;
  assign stage.last = cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      res_valid  <= 1'b0;
      fwd        <= 1'b0;
      left_score <= '0;
      diag_score <= '0;
      top_size   <= '0;
      top_row    <= '0;
      top_col    <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        fwd  <= fire && (cur.col == item.col);
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        left_score <= score;
        diag_score <= up;
        if (cur.last) begin
          top_size <= '0;
          top_row  <= '0;
          top_col  <= '0;
        end else begin
          top_size <= top_size_next;
          top_row  <= top_row_next;
          top_col  <= top_col_next;
        end
      end
      if (fire && cur.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= item;
      fwd_score <= score;
    end
    if (fire && cur.last) begin
      res_found <= (top_size_next != '0);
      res_row   <= top_row_next;
      res_col   <= top_col_next;
      res_size  <= top_size_next;
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the largest empty square finder. a scoreboard
// class keeps its own square scan and predicts one result per grid; short
// directed grids come first, then random grids, then a deep single-column grid;
// the random grids vary characters, row widths, source gaps and sink stalls
// ----------------------------------------------------------------------------

class square_tracker;
  typedef struct packed {
    logic                         found;
    logic [lesf_pkg::ROW_W-1:0]   row;
    logic [lesf_pkg::COL_W-1:0]   col;
    logic [lesf_pkg::SCORE_W-1:0] side;
  } square_t;

  logic [lesf_pkg::CHAR_W-1:0]  free_char;
  logic [lesf_pkg::CNT_W-1:0]   width_reg;
  logic [lesf_pkg::SCORE_W-1:0] line_score [lesf_pkg::MAX_COLS];
  int unsigned left_score, diag_score, row_idx, col_idx;
  int unsigned best_side, best_row, best_col;
  square_t squares_due [$];
  int errors;
  int squares_seen;

  function new();
    free_char = lesf_pkg::EMPTY_CHAR_RST;
    width_reg = lesf_pkg::ROW_WIDTH_RST;
    foreach (line_score[i]) line_score[i] = '0;
    clear_grid();
    errors = 0;
    squares_seen = 0;
  endfunction

  function void clear_grid();
    left_score = 0;
    diag_score = 0;
    row_idx = 0;
    col_idx = 0;
    best_side = 0;
    best_row = 0;
    best_col = 0;
  endfunction

  function void next_row();
    col_idx = 0;
    if (row_idx < lesf_pkg::MAX_ROWS - 1) row_idx++;
  endfunction

  function void set_reg(logic addr, logic [lesf_pkg::CNT_W-1:0] data);
    if (addr == lesf_pkg::REG_EMPTY_CHAR) free_char = data[lesf_pkg::CHAR_W-1:0];
    else width_reg = data;
  endfunction

  function int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > lesf_pkg::MAX_COLS) w = lesf_pkg::MAX_COLS;
    return w;
  endfunction

  function void take_cell(logic [lesf_pkg::CHAR_W-1:0] ch, logic is_last);
    int unsigned w, col, up, score;
    logic is_free;
    square_t sq;
    is_free = (ch == free_char);
    w = eff_width();
    if (col_idx >= w) next_row();
    col = col_idx;
    up = line_score[col];
    if (row_idx == 0 || col == 0) begin
      score = is_free ? 1 : 0;
    end else if (is_free) begin
      score = (left_score < up) ? left_score : up;
      if (diag_score < score) score = diag_score;
      score++;
      if (score > lesf_pkg::SCORE_MAX) score = lesf_pkg::SCORE_MAX;
    end else begin
      score = 0;
    end
    line_score[col] = score[lesf_pkg::SCORE_W-1:0];
    diag_score = up;
    left_score = score;
    if (score > best_side) begin
      best_side = score;
      best_row = row_idx;
      best_col = col;
    end
    if (col + 1 >= w) next_row();
    else col_idx = col + 1;
    if (is_last) begin
      sq.found = (best_side > 0);
      sq.row = best_row[lesf_pkg::ROW_W-1:0];
      sq.col = best_col[lesf_pkg::COL_W-1:0];
      sq.side = best_side[lesf_pkg::SCORE_W-1:0];
      squares_due.push_back(sq);
      clear_grid();
    end
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_square(logic found, logic [31:0] data);
    square_t want;
    if (squares_due.size() == 0) begin
      report($sformatf("result with nothing pending, tuser %b tdata %h", found, data));
      return;
    end
    want = squares_due.pop_front();
    squares_seen++;
    if (found !== want.found)
      report($sformatf("found %b, wanted %b", found, want.found));
    if (data[9:0] !== want.row)
      report($sformatf("best_row %0d, wanted %0d", data[9:0], want.row));
    if (data[19:10] !== want.col)
      report($sformatf("best_col %0d, wanted %0d", data[19:10], want.col));
    if (data[30:20] !== want.side)
      report($sformatf("best_size %0d, wanted %0d", data[30:20], want.side));
  endtask
endclass

module testbench;
  import lesf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata  = '0;
  logic             s_tlast  = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic             m_tuser;
  logic             cfg_we   = 1'b0;
  logic             cfg_addr = REG_EMPTY_CHAR;
  logic [CNT_W-1:0] cfg_data = '0;

  square_tracker tracker = new();
  int idle_pct   = 30;
  int cells_sent = 0;
  int cfg_writes = 0;
  int idle_run   = 0;
  int cur_width  = MAX_COLS;

  always #5 clk = ~clk;

  largest_empty_square_finder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_square(m_tuser, m_tdata);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_cell(input logic [7:0] ch, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_cell(ch, is_last);
    cells_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.squares_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] ch, input logic [CNT_W-1:0] w);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_EMPTY_CHAR;
    cfg_data <= CNT_W'(ch);
    @(posedge clk);
    tracker.set_reg(REG_EMPTY_CHAR, CNT_W'(ch));
    cfg_addr <= REG_ROW_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    tracker.set_reg(REG_ROW_WIDTH, w);
    cfg_we <= 1'b0;
    cfg_writes += 2;
    cur_width = (w == 0) ? 1 : (w > MAX_COLS) ? MAX_COLS : int'(w);
  endtask

  initial begin
    int len, free_pct, cut, pick, lim, grid_no, guard;
    logic [7:0] ch;
    logic [CNT_W-1:0] w_new;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset config: '.' free, full width
    send_cell(8'h00, 1'b0);
    send_cell(8'h2E, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(8'h2E, 1'b1);

    // width zero acts as one column
    drain();
    configure(8'h00, 11'd0);
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b0);
    send_cell(8'h00, 1'b1);

    // full 3x3 square
    drain();
    configure(8'hFF, 11'd3);
    for (int i = 0; i < 9; i++) send_cell(8'hFF, i == 8);

    // oversized width, no free cell
    drain();
    configure(8'h2E, 11'd2047);
    send_cell(8'h41, 1'b0);
    send_cell(8'h41, 1'b1);

    // width narrowed mid-row forces a new row
    drain();
    configure(8'h2E, 11'd4);
    for (int i = 0; i < 3; i++) send_cell(8'h2E, 1'b0);
    drain();
    configure(8'h2E, 11'd2);
    send_cell(8'h2E, 1'b0);
    send_cell(8'h2E, 1'b1);

    grid_no = 0;
    while (cells_sent < 720) begin
      idle_pct = (cells_sent >= 250 && cells_sent < 450) ? 0 : 30;
      if (grid_no % 3 == 0) begin
        drain();
        pick = $urandom_range(9);
        if (pick < 7) w_new = CNT_W'($urandom_range(1, 12));
        else if (pick == 7) w_new = '0;
        else if (pick == 8) w_new = WIDTH_MAX;
        else w_new = CNT_W'($urandom_range(MAX_COLS + 1, 2047));
        configure(8'($urandom_range(255)), w_new);
      end
      len = $urandom_range(1, 40);
      free_pct = $urandom_range(40, 95);
      cut = ($urandom_range(7) == 0 && cur_width > 1 && len > 3) ? len / 2 : -1;
      for (int i = 0; i < len; i++) begin
        if (i == cut) begin
          drain();
          lim = (cur_width > 13) ? 12 : cur_width - 1;
          configure(tracker.free_char, CNT_W'($urandom_range(1, lim)));
        end
        if ($urandom_range(99) < free_pct) ch = tracker.free_char;
        else ch = 8'($urandom_range(255));
        send_cell(ch, i == len - 1);
      end
      grid_no++;
    end

    // single column grid deep enough to saturate the row index
    idle_pct = 30;
    drain();
    configure(8'($urandom_range(255)), 11'd1);
    for (int i = 0; i < 1030; i++) begin
      if (i == 1024 || i == 1026) ch = tracker.free_char;
      else ch = tracker.free_char ^ 8'($urandom_range(1, 255));
      send_cell(ch, i == 1029);
    end

    s_tvalid <= 1'b0;
    guard = 0;
    while (tracker.squares_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.squares_due.size() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.squares_due.size()));

    $display("covered %0d cells, %0d grid results, %0d register writes",
             cells_sent, tracker.squares_seen, cfg_writes);
    $display("widths 0 to 2047, mid-row narrowing, back-to-back grids, row saturation");
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
